// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier
// no dependencies; used by every other file of the block

package bpc_pkg;

  localparam int MASK_W   = 8;
  localparam int TICK_W   = 16;
  localparam int TIME_W   = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [DATA_W-1:0] LONG_PRESS_RST = 32'd800;
  localparam logic [DATA_W-1:0] DOUBLE_WIN_RST = 32'd300;

  typedef enum logic [0:0] {
    REG_LONG_PRESS = 1'b0,
    REG_DOUBLE_WIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] long_press_ticks;
    logic [TIME_W-1:0] double_click_window;
  } cfg_t;

  // per-button events of one word
  typedef struct packed {
    logic down;
    logic up;
    logic click;
    logic lng;
    logic dbl;
    logic held;
  } lane_ev_t;

endpackage

// ===== design/bpc_in_if.sv =====
// bpc_in_if: valid/ready channel carrying one tick word
// depends on bpc_pkg for field widths

interface bpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpc_pkg::TICK_W-1:0]  elapsed_ticks;
  logic [bpc_pkg::MASK_W-1:0]  pressed_levels;

  modport source (output valid, output elapsed_ticks, output pressed_levels, input ready);
  modport sink   (input valid, input elapsed_ticks, input pressed_levels, output ready);
endinterface

// ===== design/bpc_out_if.sv =====
// bpc_out_if: valid/ready channel carrying one event word
// depends on bpc_pkg for field widths

interface bpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpc_pkg::MASK_W-1:0]  down_mask;
  logic [bpc_pkg::MASK_W-1:0]  up_mask;
  logic [bpc_pkg::MASK_W-1:0]  click_mask;
  logic [bpc_pkg::MASK_W-1:0]  long_mask;
  logic [bpc_pkg::MASK_W-1:0]  double_mask;
  logic [bpc_pkg::MASK_W-1:0]  held_mask;

  modport source (output valid, output down_mask, output up_mask, output click_mask,
                  output long_mask, output double_mask, output held_mask, input ready);
  modport sink   (input valid, input down_mask, input up_mask, input click_mask,
                  input long_mask, input double_mask, input held_mask, output ready);
endinterface

// ===== design/button_press_classifier.sv =====
// button_press_classifier: click, long press and double click detector, top level
// an accepted word is registered in the input register; its result word is registered in the output register
// throughput: one word per cycle while the output is not stalled; input register, per-button lanes, output register
// while a result waits, one more word is taken into an empty input register, then input stalls
// reset: rst_n synchronous active low; clears time, lane state and valids, loads config registers with reset values
// depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg, bpc_lane

module button_press_classifier #(
  parameter int BUTTONS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bpc_in_if.sink                      in_ch,
  bpc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // only buttons that fit the 8-bit fields can ever change state
  localparam int LANES = (BUTTONS < bpc_pkg::MASK_W) ? BUTTONS : bpc_pkg::MASK_W;

  bpc_pkg::cfg_t               cfg;
  logic                        in_vld_r;
  logic [bpc_pkg::TICK_W-1:0]  in_tick_r;
  logic [bpc_pkg::MASK_W-1:0]  in_lvl_r;
  logic [bpc_pkg::TIME_W-1:0]  in_time_r;
  logic [bpc_pkg::TIME_W-1:0]  time_r;
  logic [bpc_pkg::TIME_W-1:0]  time_nxt;
  logic                        out_vld_r;
  logic                        adv;
  logic                        upd;
  bpc_pkg::lane_ev_t           ev [LANES];
  logic [bpc_pkg::MASK_W-1:0]  down_nxt, up_nxt, click_nxt, long_nxt, dbl_nxt, held_nxt;
  logic [bpc_pkg::MASK_W-1:0]  down_r, up_r, click_r, long_r, dbl_r, held_r;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || adv;
  assign upd         = adv && in_vld_r;

  // time only depends on the tick stream, so it advances at accept
  assign time_nxt = time_r + {{(bpc_pkg::TIME_W-bpc_pkg::TICK_W){1'b0}}, in_ch.elapsed_ticks};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      time_r   <= '0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
      if (in_ch.valid) begin
        time_r <= time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_tick_r <= in_ch.elapsed_ticks;
      in_lvl_r  <= in_ch.pressed_levels;
      in_time_r <= time_nxt;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bpc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (upd),
      .level    (in_lvl_r[g]),
      .tick     (in_tick_r),
      .time_now (in_time_r),
      .cfg      (cfg),
      .ev       (ev[g])
    );
  end

  always_comb begin
    down_nxt  = '0;
    up_nxt    = '0;
    click_nxt = '0;
    long_nxt  = '0;
    dbl_nxt   = '0;
    held_nxt  = '0;
    for (int i = 0; i < LANES; i++) begin
      down_nxt[i]  = ev[i].down;
      up_nxt[i]    = ev[i].up;
      click_nxt[i] = ev[i].click;
      long_nxt[i]  = ev[i].lng;
      dbl_nxt[i]   = ev[i].dbl;
      held_nxt[i]  = ev[i].held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      down_r  <= down_nxt;
      up_r    <= up_nxt;
      click_r <= click_nxt;
      long_r  <= long_nxt;
      dbl_r   <= dbl_nxt;
      held_r  <= held_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.down_mask   = down_r;
  assign out_ch.up_mask     = up_r;
  assign out_ch.click_mask  = click_r;
  assign out_ch.long_mask   = long_r;
  assign out_ch.double_mask = dbl_r;
  assign out_ch.held_mask   = held_r;

endmodule

// ===== design/bpc_cfg.sv =====
// bpc_cfg: APB-style register file holding the long press and double click settings
// depends on bpc_pkg

module bpc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bpc_pkg::cfg_t               cfg
);

  logic [bpc_pkg::DATA_W-1:0] long_press_r;
  logic [bpc_pkg::DATA_W-1:0] double_win_r;
  bpc_pkg::reg_idx_t          idx;
  logic                       wr_en;

  assign pready = 1'b1;
  assign idx    = bpc_pkg::reg_idx_t'(paddr[bpc_pkg::ADDR_W-1]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= bpc_pkg::LONG_PRESS_RST;
      double_win_r <= bpc_pkg::DOUBLE_WIN_RST;
    end else if (wr_en) begin
      case (idx)
        bpc_pkg::REG_LONG_PRESS: long_press_r <= pwdata;
        bpc_pkg::REG_DOUBLE_WIN: double_win_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::REG_LONG_PRESS: prdata = long_press_r;
      bpc_pkg::REG_DOUBLE_WIN: prdata = double_win_r;
      default:                 prdata = '0;
    endcase
  end

  assign cfg.long_press_ticks    = long_press_r;
  assign cfg.double_click_window = double_win_r;

endmodule

// ===== design/bpc_lane.sv =====
// bpc_lane: state and classification for one button
// depends on bpc_pkg

module bpc_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic                        level,
  input  logic [bpc_pkg::TICK_W-1:0]  tick,
  input  logic [bpc_pkg::TIME_W-1:0]  time_now,
  input  bpc_pkg::cfg_t               cfg,
  output bpc_pkg::lane_ev_t           ev
);

  logic                        last_r;
  logic [bpc_pkg::TIME_W-1:0]  stamp_r;
  logic [bpc_pkg::TIME_W-1:0]  remain_r;
  logic                        last_nxt;
  logic [bpc_pkg::TIME_W-1:0]  stamp_nxt;
  logic [bpc_pkg::TIME_W-1:0]  remain_nxt;
  logic [bpc_pkg::TIME_W-1:0]  tick_ext;
  logic [bpc_pkg::TIME_W-1:0]  remain_dec;
  logic [bpc_pkg::TIME_W-1:0]  held_dur;
  logic                        dbl_on;

  assign tick_ext = {{(bpc_pkg::TIME_W-bpc_pkg::TICK_W){1'b0}}, tick};
  assign dbl_on   = (cfg.double_click_window != '0);
  assign held_dur = time_now - stamp_r;

  always_comb begin
    // countdown saturates at zero; frozen while the window is disabled
    if (dbl_on) begin
      remain_dec = (remain_r > tick_ext) ? (remain_r - tick_ext) : '0;
    end else begin
      remain_dec = remain_r;
    end

    last_nxt   = level;
    stamp_nxt  = stamp_r;
    remain_nxt = remain_dec;
    ev         = '0;

    if (level != last_r) begin
      if (level) begin
        stamp_nxt = time_now;
        ev.down   = 1'b1;
      end else begin
        ev.up = 1'b1;
        if ((cfg.long_press_ticks != '0) && (held_dur > cfg.long_press_ticks)) begin
          ev.lng = 1'b1;
        end else if (dbl_on && (remain_dec != '0)) begin
          remain_nxt = '0;
          ev.dbl     = 1'b1;
        end else begin
          if (dbl_on) begin
            remain_nxt = cfg.double_click_window;
          end
          ev.click = 1'b1;
        end
      end
    end else if (level) begin
      ev.held = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      stamp_r  <= '0;
      remain_r <= '0;
    end else if (upd) begin
      last_r   <= last_nxt;
      stamp_r  <= stamp_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for button_press_classifier, driving tick words through the
// input channel and comparing every event word against an in-bench per-button predictor
// depends on bpc_pkg, bpc_in_if, bpc_out_if and the button_press_classifier design files

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bpc_pkg::TICK_W-1:0] tick_t;
  typedef logic [bpc_pkg::MASK_W-1:0] mask_t;

  typedef struct packed {
    logic [bpc_pkg::TICK_W-1:0] ticks;
    logic [bpc_pkg::MASK_W-1:0] levels;
  } tick_word_t;

  typedef struct packed {
    logic [bpc_pkg::MASK_W-1:0] down;
    logic [bpc_pkg::MASK_W-1:0] up;
    logic [bpc_pkg::MASK_W-1:0] click;
    logic [bpc_pkg::MASK_W-1:0] lng;
    logic [bpc_pkg::MASK_W-1:0] dbl;
    logic [bpc_pkg::MASK_W-1:0] held;
  } event_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bpc_pkg::ADDR_W-1:0] paddr;
  logic [bpc_pkg::DATA_W-1:0] pwdata;
  logic [bpc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  button_press_classifier uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier state as the bench sees it
  logic [bpc_pkg::TIME_W-1:0] clock_now;
  logic [bpc_pkg::TIME_W-1:0] long_cfg;
  logic [bpc_pkg::TIME_W-1:0] window_cfg;
  logic [bpc_pkg::MASK_W-1:0] level_q;
  logic [bpc_pkg::TIME_W-1:0] stamp_q [bpc_pkg::MASK_W];
  logic [bpc_pkg::TIME_W-1:0] countdown_q [bpc_pkg::MASK_W];

  tick_word_t  words_to_send [$];
  event_word_t events_due [$];

  logic [bpc_pkg::MASK_W-1:0] levels_sent;
  bit                in_idle_on;
  bit                out_idle_on;
  int unsigned       hold_requests;
  int unsigned       holds_done;
  int unsigned       stall_left;
  int unsigned       gap_left;
  int unsigned       mismatches;
  int unsigned       words_seen;
  tick_word_t        next_word;
  event_word_t       got_word;
  event_word_t       want_word;

  function automatic event_word_t classify_tick(logic [bpc_pkg::TICK_W-1:0] ticks,
                                                logic [bpc_pkg::MASK_W-1:0] levels);
    event_word_t ev;
    logic [bpc_pkg::TIME_W-1:0] held_for;
    logic [bpc_pkg::TIME_W-1:0] tick_ext;
    ev = '0;
    tick_ext = {{(bpc_pkg::TIME_W-bpc_pkg::TICK_W){1'b0}}, ticks};
    clock_now = clock_now + tick_ext;
    for (int b = 0; b < bpc_pkg::MASK_W; b++) begin
      if (window_cfg != 0 && countdown_q[b] != 0)
        countdown_q[b] = (countdown_q[b] > tick_ext) ? countdown_q[b] - tick_ext : '0;
      if (levels[b] != level_q[b]) begin
        level_q[b] = levels[b];
        if (levels[b]) begin
          stamp_q[b] = clock_now;
          ev.down[b] = 1'b1;
        end else begin
          ev.up[b] = 1'b1;
          held_for = clock_now - stamp_q[b];
          if (long_cfg != 0 && held_for > long_cfg) begin
            ev.lng[b] = 1'b1;
          end else if (window_cfg != 0 && countdown_q[b] != 0) begin
            countdown_q[b] = '0;
            ev.dbl[b] = 1'b1;
          end else begin
            if (window_cfg != 0) countdown_q[b] = window_cfg;
            ev.click[b] = 1'b1;
          end
        end
      end else if (levels[b]) begin
        ev.held[b] = 1'b1;
      end
    end
    return ev;
  endfunction

  function automatic void check_mask(string field, logic [bpc_pkg::MASK_W-1:0] want,
                                     logic [bpc_pkg::MASK_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d: %s expected %h, got %h", words_seen, field, want, got);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!in_idle_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_word(logic [bpc_pkg::TICK_W-1:0] ticks,
                                    logic [bpc_pkg::MASK_W-1:0] levels);
    tick_word_t w;
    w.ticks = ticks;
    w.levels = levels;
    words_to_send.push_back(w);
    levels_sent = levels;
  endfunction

  // driver: predicts each word as it is accepted, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid)
        events_due.push_back(classify_tick(in_ch.elapsed_ticks, in_ch.pressed_levels));
      if (gap_left != 0 || words_to_send.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        next_word = words_to_send.pop_front();
        in_ch.elapsed_ticks <= next_word.ticks;
        in_ch.pressed_levels <= next_word.levels;
        in_ch.valid <= 1'b1;
        gap_left <= pick_gap();
      end
    end
  end

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      out_ch.ready <= 1'b0;
      stall_left <= 80;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!out_idle_on || r < 70) begin
      out_ch.ready <= 1'b1;
    end else if (r < 95) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_word = '{out_ch.down_mask, out_ch.up_mask, out_ch.click_mask,
                   out_ch.long_mask, out_ch.double_mask, out_ch.held_mask};
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("word %0d: event word with none expected: %h",
                                       words_seen, got_word);
      end else begin
        want_word = events_due.pop_front();
        check_mask("down_mask", want_word.down, got_word.down);
        check_mask("up_mask", want_word.up, got_word.up);
        check_mask("click_mask", want_word.click, got_word.click);
        check_mask("long_mask", want_word.lng, got_word.lng);
        check_mask("double_mask", want_word.dbl, got_word.dbl);
        check_mask("held_mask", want_word.held, got_word.held);
      end
      words_seen++;
    end
  end

  task automatic write_reg(bpc_pkg::reg_idx_t idx, logic [bpc_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == bpc_pkg::REG_LONG_PRESS) long_cfg = value;
    else window_cfg = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_ch.valid || events_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_random(int count, bit hold);
    logic [bpc_pkg::TICK_W-1:0] ticks;
    logic [bpc_pkg::MASK_W-1:0] lv;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        lv = mask_t'($urandom);
      end else begin
        lv = levels_sent;
        for (int b = 0; b < bpc_pkg::MASK_W; b++)
          if ($urandom_range(0, 5) == 0) lv[b] = ~lv[b];
      end
      r = $urandom_range(0, 99);
      if (r < 10) ticks = '0;
      else if (r < 55) ticks = tick_t'($urandom_range(1, 60));
      else if (r < 80) ticks = tick_t'($urandom_range(0, 600));
      else if (r < 92) ticks = tick_t'($urandom_range(0, 5000));
      else if (r < 97) ticks = tick_t'($urandom);
      else ticks = '1;
      push_word(ticks, lv);
    end
    if (hold) hold_requests++;
  endtask

  function automatic logic [2*bpc_pkg::TIME_W-1:0] phase_cfg(int p);
    case (p)
      0: return {32'd800, 32'd300};
      1: return {32'd0, 32'd300};
      2: return {32'd1, 32'd1};
      3: return {32'hFFFF_FFFF, 32'hFFFF_FFFF};
      4: return {32'd200, 32'd0};
      5: return {32'd50, 32'd500};
      6: return {32'd0, 32'd0};
      default: return {32'd3000, 32'd100};
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [2*bpc_pkg::TIME_W-1:0] cfg;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.elapsed_ticks = '0;
    in_ch.pressed_levels = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clock_now = '0;
    long_cfg = bpc_pkg::LONG_PRESS_RST;
    window_cfg = bpc_pkg::DOUBLE_WIN_RST;
    level_q = '0;
    for (int b = 0; b < bpc_pkg::MASK_W; b++) begin
      stamp_q[b] = '0;
      countdown_q[b] = '0;
    end
    levels_sent = '0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    hold_requests = 0;
    holds_done = 0;
    mismatches = 0;
    words_seen = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset thresholds
    push_word(16'd0, 8'h00);
    push_word(16'hFFFF, 8'hFF);
    push_word(16'd10, 8'hFF);
    push_word(16'd0, 8'h00);
    push_word(16'd100, 8'hFF);
    push_word(16'd50, 8'h00);
    push_word(16'hAAAA, 8'h55);
    push_word(16'h5555, 8'hAA);
    push_word(16'd800, 8'h00);    // held exactly the threshold: still a click
    push_word(16'd300, 8'h00);    // countdown runs out exactly
    push_word(16'd0, 8'h01);
    push_word(16'd801, 8'h00);    // one past the threshold: long
    push_word(16'd0, 8'h02);
    push_word(16'd0, 8'h00);
    push_word(16'd299, 8'h02);
    push_word(16'd0, 8'h00);      // double with one tick left
    push_word(16'hFFFF, 8'h00);
    wait_drained();

    // countdown stays frozen while the window is off
    push_word(16'd0, 8'h04);
    push_word(16'd0, 8'h00);
    wait_drained();
    write_reg(bpc_pkg::REG_DOUBLE_WIN, 32'd0);
    push_word(16'd50, 8'h04);
    push_word(16'd0, 8'h00);
    wait_drained();
    write_reg(bpc_pkg::REG_DOUBLE_WIN, 32'd300);
    push_word(16'd250, 8'h04);
    push_word(16'd0, 8'h00);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      cfg = phase_cfg(p);
      write_reg(bpc_pkg::REG_LONG_PRESS, cfg[2*bpc_pkg::TIME_W-1:bpc_pkg::TIME_W]);
      write_reg(bpc_pkg::REG_DOUBLE_WIN, cfg[bpc_pkg::TIME_W-1:0]);
      in_idle_on = (p != 3);
      out_idle_on = (p != 3);
      run_random(80, p == 5 || p == 1);
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
